@@ sv/tlpc_pkg.sv @@
// tlpc_pkg: shared types, codes and decode functions for the traffic light
// phase controller
// no dependencies

package tlpc_pkg;

  // one-hot phase state
  typedef enum logic [6:0] {
    PH_NS_GREEN  = 7'b0000001,
    PH_NS_YELLOW = 7'b0000010,
    PH_EW_GREEN  = 7'b0000100,
    PH_EW_YELLOW = 7'b0001000,
    PH_ALL_RED   = 7'b0010000,
    PH_WALK      = 7'b0100000,
    PH_EMERGENCY = 7'b1000000
  } phase_e;

  localparam logic [2:0] CODE_NS_GREEN  = 3'd0;
  localparam logic [2:0] CODE_NS_YELLOW = 3'd1;
  localparam logic [2:0] CODE_EW_GREEN  = 3'd2;
  localparam logic [2:0] CODE_EW_YELLOW = 3'd3;
  localparam logic [2:0] CODE_ALL_RED   = 3'd4;
  localparam logic [2:0] CODE_WALK      = 3'd5;
  localparam logic [2:0] CODE_EMERGENCY = 3'd6;

  localparam logic [1:0] LAMP_RED    = 2'd0;
  localparam logic [1:0] LAMP_YELLOW = 2'd1;
  localparam logic [1:0] LAMP_GREEN  = 2'd2;

  localparam logic [1:0] CFG_GREEN   = 2'd0;
  localparam logic [1:0] CFG_YELLOW  = 2'd1;
  localparam logic [1:0] CFG_ALL_RED = 2'd2;
  localparam logic [1:0] CFG_WALK    = 2'd3;

  localparam int unsigned TICK_W = 16;

  localparam logic [TICK_W-1:0] GREEN_RST   = 16'd10;
  localparam logic [TICK_W-1:0] YELLOW_RST  = 16'd3;
  localparam logic [TICK_W-1:0] ALL_RED_RST = 16'd2;
  localparam logic [TICK_W-1:0] WALK_RST    = 16'd8;

  typedef logic [TICK_W-1:0] ticks_t;

  function automatic logic [2:0] phase_code(phase_e ph);
    logic [2:0] code;
    code = CODE_ALL_RED;
    unique case (ph)
      PH_NS_GREEN:  code = CODE_NS_GREEN;
      PH_NS_YELLOW: code = CODE_NS_YELLOW;
      PH_EW_GREEN:  code = CODE_EW_GREEN;
      PH_EW_YELLOW: code = CODE_EW_YELLOW;
      PH_ALL_RED:   code = CODE_ALL_RED;
      PH_WALK:      code = CODE_WALK;
      PH_EMERGENCY: code = CODE_EMERGENCY;
      default:      code = CODE_ALL_RED;
    endcase
    return code;
  endfunction

  function automatic logic [1:0] ns_lamp(phase_e ph);
    logic [1:0] lamp;
    lamp = LAMP_RED;
    case (ph)
      PH_NS_GREEN:  lamp = LAMP_GREEN;
      PH_NS_YELLOW: lamp = LAMP_YELLOW;
      default:      lamp = LAMP_RED;
    endcase
    return lamp;
  endfunction

  function automatic logic [1:0] ew_lamp(phase_e ph);
    logic [1:0] lamp;
    lamp = LAMP_RED;
    case (ph)
      PH_EW_GREEN:  lamp = LAMP_GREEN;
      PH_EW_YELLOW: lamp = LAMP_YELLOW;
      default:      lamp = LAMP_RED;
    endcase
    return lamp;
  endfunction

endpackage

@@ sv/traffic_light_phase_controller_top.sv @@
// traffic_light_phase_controller_top: seven-phase intersection sequencer
// with request latches, tick down-counter and registered result word
// depends on tlpc_pkg
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i / in_stall_o  tick, ped_ns/ew_press, siren_press
//   out      output     out_valid_o / out_stall_i  phase, lamps, walk, emergency, pending
//   cfg      input      cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
// one word per cycle while in_stall_o is low; a result appears in the cycle after its word is taken
// the phase register and down-counter update in the accepting cycle
// in_stall_o is high only while a result sits in the output register and is stalled
// reset: all red with two ticks to go, NS green next, no requests pending

module traffic_light_phase_controller_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        tick_i,
  input  logic        ped_ns_press_i,
  input  logic        ped_ew_press_i,
  input  logic        siren_press_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  phase_o,
  output logic [1:0]  ns_lamp_o,
  output logic [1:0]  ew_lamp_o,
  output logic        walk_on_o,
  output logic        emergency_on_o,
  output logic [2:0]  pending_requests_o
);

  tlpc_pkg::ticks_t green_q, yellow_q, all_red_q, walk_q;

  tlpc_pkg::phase_e cur_q, cur_d, fol_q, fol_d;
  tlpc_pkg::ticks_t rem_q, rem_d;
  logic             ped_ns_q, ped_ns_d, ped_ew_q, ped_ew_d, siren_q, siren_d;

  logic             out_valid_q;
  logic [2:0]       phase_q;
  logic [1:0]       ns_lamp_q, ew_lamp_q;
  logic             walk_on_q, emergency_on_q;
  logic [2:0]       pending_q;

  logic             in_acc;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      green_q   <= tlpc_pkg::GREEN_RST;
      yellow_q  <= tlpc_pkg::YELLOW_RST;
      all_red_q <= tlpc_pkg::ALL_RED_RST;
      walk_q    <= tlpc_pkg::WALK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tlpc_pkg::CFG_GREEN:   green_q   <= cfg_wdata_i;
        tlpc_pkg::CFG_YELLOW:  yellow_q  <= cfg_wdata_i;
        tlpc_pkg::CFG_ALL_RED: all_red_q <= cfg_wdata_i;
        tlpc_pkg::CFG_WALK:    walk_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // next phase, count and latches for one word
  always_comb begin
    logic lat_ns, lat_ew, lat_siren;
    lat_ns    = ped_ns_q | ped_ns_press_i;
    lat_ew    = ped_ew_q | ped_ew_press_i;
    lat_siren = siren_q | siren_press_i;
    cur_d     = cur_q;
    fol_d     = fol_q;
    rem_d     = rem_q;
    ped_ns_d  = lat_ns;
    ped_ew_d  = lat_ew;
    siren_d   = lat_siren;
    if (tick_i) begin
      if (rem_q <= tlpc_pkg::ticks_t'(1)) begin
        cur_d = fol_q;
        unique case (fol_q)
          tlpc_pkg::PH_NS_GREEN: begin
            rem_d = green_q;
            fol_d = tlpc_pkg::PH_NS_YELLOW;
          end
          tlpc_pkg::PH_NS_YELLOW: begin
            rem_d = yellow_q;
            fol_d = tlpc_pkg::PH_EW_GREEN;
          end
          tlpc_pkg::PH_EW_GREEN: begin
            rem_d = green_q;
            fol_d = tlpc_pkg::PH_EW_YELLOW;
          end
          tlpc_pkg::PH_EW_YELLOW: begin
            rem_d = yellow_q;
            fol_d = tlpc_pkg::PH_ALL_RED;
          end
          tlpc_pkg::PH_ALL_RED: begin
            rem_d = all_red_q;
            if (lat_ns || lat_ew) begin
              fol_d = tlpc_pkg::PH_WALK;
            end else if (lat_siren) begin
              fol_d = tlpc_pkg::PH_EMERGENCY;
            end else begin
              fol_d = tlpc_pkg::PH_NS_GREEN;
            end
          end
          tlpc_pkg::PH_WALK: begin
            rem_d    = walk_q;
            ped_ns_d = 1'b0;
            ped_ew_d = 1'b0;
            fol_d    = tlpc_pkg::PH_NS_GREEN;
          end
          tlpc_pkg::PH_EMERGENCY: begin
            rem_d   = all_red_q;
            siren_d = 1'b0;
            fol_d   = tlpc_pkg::PH_ALL_RED;
          end
          default: begin
            cur_d = tlpc_pkg::PH_ALL_RED;
            rem_d = all_red_q;
            fol_d = tlpc_pkg::PH_NS_GREEN;
          end
        endcase
      end else begin
        rem_d = rem_q - tlpc_pkg::ticks_t'(1);
      end
    end
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q    <= tlpc_pkg::PH_ALL_RED;
      fol_q    <= tlpc_pkg::PH_NS_GREEN;
      rem_q    <= tlpc_pkg::ALL_RED_RST;
      ped_ns_q <= 1'b0;
      ped_ew_q <= 1'b0;
      siren_q  <= 1'b0;
    end else if (in_acc) begin
      cur_q    <= cur_d;
      fol_q    <= fol_d;
      rem_q    <= rem_d;
      ped_ns_q <= ped_ns_d;
      ped_ew_q <= ped_ew_d;
      siren_q  <= siren_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      phase_q        <= tlpc_pkg::phase_code(cur_d);
      ns_lamp_q      <= tlpc_pkg::ns_lamp(cur_d);
      ew_lamp_q      <= tlpc_pkg::ew_lamp(cur_d);
      walk_on_q      <= (cur_d == tlpc_pkg::PH_WALK);
      emergency_on_q <= (cur_d == tlpc_pkg::PH_EMERGENCY);
      pending_q      <= {siren_d, ped_ew_d, ped_ns_d};
    end
  end

  assign out_valid_o        = out_valid_q;
  assign phase_o            = phase_q;
  assign ns_lamp_o          = ns_lamp_q;
  assign ew_lamp_o          = ew_lamp_q;
  assign walk_on_o          = walk_on_q;
  assign emergency_on_o     = emergency_on_q;
  assign pending_requests_o = pending_q;

`ifndef SYNTHESIS
  a_acc_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("accepted word gave no result");

  a_no_accept_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !in_acc)
    else $error("word accepted over a stalled result");

  a_walk_lamps_red : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && walk_on_q) |->
      (ns_lamp_q == tlpc_pkg::LAMP_RED && ew_lamp_q == tlpc_pkg::LAMP_RED && !emergency_on_q))
    else $error("lamps not red during walk");

  a_walk_clears_ped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && cur_q != tlpc_pkg::PH_WALK && cur_d == tlpc_pkg::PH_WALK) |=>
      (!ped_ns_q && !ped_ew_q))
    else $error("pedestrian latches survive walk entry");

  a_emerg_clears_siren : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && cur_q != tlpc_pkg::PH_EMERGENCY && cur_d == tlpc_pkg::PH_EMERGENCY) |=>
      !siren_q)
    else $error("siren latch survives emergency entry");
`endif

endmodule

@@ sim/tlpc_lights_checker.sv @@
// tlpc_lights_checker: follows the word channels and timing writes of the phase controller,
// predicts every result word and compares it field by field with what comes out
// depends on tlpc_pkg

module tlpc_lights_checker
  import tlpc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        tick_i,
  input  logic        ped_ns_press_i,
  input  logic        ped_ew_press_i,
  input  logic        siren_press_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  phase_i,
  input  logic [1:0]  ns_lamp_i,
  input  logic [1:0]  ew_lamp_i,
  input  logic        walk_on_i,
  input  logic        emergency_on_i,
  input  logic [2:0]  pending_requests_i,
  output int unsigned words_outstanding_o,
  output int unsigned fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REQ_PED_NS = 0;
  localparam int REQ_PED_EW = 1;
  localparam int REQ_SIREN  = 2;

  typedef struct packed {
    logic [2:0] phase;
    logic [1:0] ns_lamp;
    logic [1:0] ew_lamp;
    logic       walk_on;
    logic       emergency_on;
    logic [2:0] pending;
  } lights_t;

  ticks_t     timing [4];
  logic [2:0] cur_phase;
  logic [2:0] next_phase;
  ticks_t     ticks_left;
  logic [2:0] requests;
  lights_t    expected_lights_q [$];

  initial begin
    fail_count_o = 0;
    words_outstanding_o = 0;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (fail_count_o < 100)
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  function automatic void enter_phase(input logic [2:0] ph);
    cur_phase = ph;
    case (ph)
      CODE_NS_GREEN: begin
        ticks_left = timing[CFG_GREEN];
        next_phase = CODE_NS_YELLOW;
      end
      CODE_NS_YELLOW: begin
        ticks_left = timing[CFG_YELLOW];
        next_phase = CODE_EW_GREEN;
      end
      CODE_EW_GREEN: begin
        ticks_left = timing[CFG_GREEN];
        next_phase = CODE_EW_YELLOW;
      end
      CODE_EW_YELLOW: begin
        ticks_left = timing[CFG_YELLOW];
        next_phase = CODE_ALL_RED;
      end
      CODE_ALL_RED: begin
        ticks_left = timing[CFG_ALL_RED];
        if (requests[REQ_PED_NS] || requests[REQ_PED_EW])
          next_phase = CODE_WALK;
        else if (requests[REQ_SIREN])
          next_phase = CODE_EMERGENCY;
        else
          next_phase = CODE_NS_GREEN;
      end
      CODE_WALK: begin
        ticks_left = timing[CFG_WALK];
        requests[REQ_PED_NS] = 1'b0;
        requests[REQ_PED_EW] = 1'b0;
        next_phase = CODE_NS_GREEN;
      end
      CODE_EMERGENCY: begin
        ticks_left = timing[CFG_ALL_RED];
        requests[REQ_SIREN] = 1'b0;
        next_phase = CODE_ALL_RED;
      end
      default: begin
        ticks_left = ticks_t'(1);
        next_phase = CODE_ALL_RED;
      end
    endcase
  endfunction

  function automatic lights_t predict_lights(input logic tick, input logic ped_ns,
                                             input logic ped_ew, input logic siren);
    lights_t r;
    // requests latch before the tick is applied
    if (ped_ns) requests[REQ_PED_NS] = 1'b1;
    if (ped_ew) requests[REQ_PED_EW] = 1'b1;
    if (siren)  requests[REQ_SIREN]  = 1'b1;
    if (tick) begin
      if (ticks_left <= 1)
        enter_phase(next_phase);
      else
        ticks_left = ticks_left - 1'b1;
    end
    r.phase = cur_phase;
    r.ns_lamp = LAMP_RED;
    r.ew_lamp = LAMP_RED;
    case (cur_phase)
      CODE_NS_GREEN:  r.ns_lamp = LAMP_GREEN;
      CODE_NS_YELLOW: r.ns_lamp = LAMP_YELLOW;
      CODE_EW_GREEN:  r.ew_lamp = LAMP_GREEN;
      CODE_EW_YELLOW: r.ew_lamp = LAMP_YELLOW;
      default: ;
    endcase
    r.walk_on = (cur_phase == CODE_WALK);
    r.emergency_on = (cur_phase == CODE_EMERGENCY);
    r.pending = requests;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lights_t got;
    lights_t want;
    if (!rst_ni) begin
      timing[CFG_GREEN]   = GREEN_RST;
      timing[CFG_YELLOW]  = YELLOW_RST;
      timing[CFG_ALL_RED] = ALL_RED_RST;
      timing[CFG_WALK]    = WALK_RST;
      cur_phase  = CODE_ALL_RED;
      next_phase = CODE_NS_GREEN;
      ticks_left = ALL_RED_RST;
      requests   = '0;
      expected_lights_q.delete();
      words_outstanding_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = {phase_i, ns_lamp_i, ew_lamp_i, walk_on_i, emergency_on_i, pending_requests_i};
        if (expected_lights_q.size() == 0) begin
          report_mismatch("unexpected result word", got, 0);
        end else begin
          want = expected_lights_q.pop_front();
          if (got.phase !== want.phase)
            report_mismatch("phase", got.phase, want.phase);
          if (got.ns_lamp !== want.ns_lamp)
            report_mismatch("ns_lamp", got.ns_lamp, want.ns_lamp);
          if (got.ew_lamp !== want.ew_lamp)
            report_mismatch("ew_lamp", got.ew_lamp, want.ew_lamp);
          if (got.walk_on !== want.walk_on)
            report_mismatch("walk_on", got.walk_on, want.walk_on);
          if (got.emergency_on !== want.emergency_on)
            report_mismatch("emergency_on", got.emergency_on, want.emergency_on);
          if (got.pending !== want.pending)
            report_mismatch("pending_requests", got.pending, want.pending);
        end
      end
      // new timings only take effect on the next phase entry
      if (cfg_we_i)
        timing[cfg_idx_i] = cfg_wdata_i;
      if (in_valid_i && !in_stall_i)
        expected_lights_q.push_back(predict_lights(tick_i, ped_ns_press_i,
                                                   ped_ew_press_i, siren_press_i));
      words_outstanding_o <= expected_lights_q.size();
    end
  end

endmodule

@@ sim/traffic_light_phase_controller_top_test.sv @@
// traffic_light_phase_controller_top_test: drives request words and timing writes into the
// phase controller under varying idle and stall rates and gives the verdict
// depends on tlpc_pkg, traffic_light_phase_controller_top and tlpc_lights_checker

module traffic_light_phase_controller_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tlpc_pkg::*;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WORDS_PER_PHASE = 220;
  localparam int NUM_PHASES      = 8;

  // word layout: {siren, ped_ew, ped_ns, tick}
  localparam logic [3:0] OPENING_WORDS [24] = '{
    4'b0000, 4'b1111, 4'b0001, 4'b0001, 4'b0001, 4'b0001, 4'b0001, 4'b1001,
    4'b0101, 4'b0001, 4'b0001, 4'b0001, 4'b0001, 4'b0001, 4'b0001, 4'b0001,
    4'b0001, 4'b0001, 4'b0001, 4'b1011, 4'b0001, 4'b0111, 4'b1110, 4'b0001
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = CFG_GREEN;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        tick = 1'b0;
  logic        ped_ns_press = 1'b0;
  logic        ped_ew_press = 1'b0;
  logic        siren_press = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  phase;
  logic [1:0]  ns_lamp;
  logic [1:0]  ew_lamp;
  logic        walk_on;
  logic        emergency_on;
  logic [2:0]  pending_requests;

  int unsigned words_outstanding;
  int unsigned fail_count;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          press_pct = 6;
  int          hold_off_req = 0;
  int          hold_off_done = 0;
  int          quiet_cycles = 0;

  traffic_light_phase_controller_top dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .tick_i             (tick),
    .ped_ns_press_i     (ped_ns_press),
    .ped_ew_press_i     (ped_ew_press),
    .siren_press_i      (siren_press),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .phase_o            (phase),
    .ns_lamp_o          (ns_lamp),
    .ew_lamp_o          (ew_lamp),
    .walk_on_o          (walk_on),
    .emergency_on_o     (emergency_on),
    .pending_requests_o (pending_requests)
  );

  tlpc_lights_checker lights_check (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_idx_i           (cfg_idx),
    .cfg_wdata_i         (cfg_wdata),
    .in_valid_i          (in_valid),
    .in_stall_i          (in_stall),
    .tick_i              (tick),
    .ped_ns_press_i      (ped_ns_press),
    .ped_ew_press_i      (ped_ew_press),
    .siren_press_i       (siren_press),
    .out_valid_i         (out_valid),
    .out_stall_i         (out_stall),
    .phase_i             (phase),
    .ns_lamp_i           (ns_lamp),
    .ew_lamp_i           (ew_lamp),
    .walk_on_i           (walk_on),
    .emergency_on_i      (emergency_on),
    .pending_requests_i  (pending_requests),
    .words_outstanding_o (words_outstanding),
    .fail_count_o        (fail_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stalls, with the odd long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req != hold_off_done) begin
        hold_off_done = hold_off_req;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [3:0] roll_word();
    logic [3:0] w;
    w[0] = ($urandom_range(99) < 75);
    w[1] = ($urandom_range(99) < press_pct);
    w[2] = ($urandom_range(99) < press_pct);
    w[3] = ($urandom_range(99) < press_pct);
    return w;
  endfunction

  task automatic send_word(input logic [3:0] w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {siren_press, ped_ew_press, ped_ns_press, tick} <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic settle_channels();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_outstanding != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic program_timings(input ticks_t green, input ticks_t yellow,
                                 input ticks_t all_red, input ticks_t walk);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_GREEN;
    cfg_wdata <= green;
    @(posedge clk);
    cfg_idx <= CFG_YELLOW;
    cfg_wdata <= yellow;
    @(posedge clk);
    cfg_idx <= CFG_ALL_RED;
    cfg_wdata <= all_red;
    @(posedge clk);
    cfg_idx <= CFG_WALK;
    cfg_wdata <= walk;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle_channels();
      case (p)
        0: program_timings(ticks_t'(1), ticks_t'(1), ticks_t'(1), ticks_t'(1));
        1: program_timings('0, '0, '0, '0);
        2: program_timings(GREEN_RST, YELLOW_RST, ALL_RED_RST, WALK_RST);
        NUM_PHASES - 1: program_timings('1, '1, '1, '1);
        default: program_timings(ticks_t'($urandom_range(6)), ticks_t'($urandom_range(6)),
                                 ticks_t'($urandom_range(6)), ticks_t'($urandom_range(6)));
      endcase
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 72; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 72; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      press_pct = $urandom_range(1, 12);
      if (p == 0)
        for (int k = 0; k < 24; k++) send_word(OPENING_WORDS[k]);
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        if ((p % 4 == 0) && (i == 20))
          hold_off_req++;
        send_word(roll_word());
      end
    end
    settle_channels();
    if (fail_count == 0 && words_outstanding == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
